>>> rtl/core/gpbp_pkg.sv
package gpbp_pkg;

  // Number of palette entries that an index is folded into.
  localparam int PALETTE_SIZE = 16;
  localparam logic [8:0] PALETTE_SIZE_V = 9'(PALETTE_SIZE);

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_LENGTH      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_OFFSET      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_LENGTH    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_OFFSET    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_LENGTH     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_OFFSET     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_BACKGROUND = 3'd7;

  // Pixel size codes.
  localparam logic [2:0] PB_INDEXED = 3'd1;
  localparam logic [2:0] PB_RGB16   = 3'd2;
  localparam logic [2:0] PB_RGB32   = 3'd4;

  // Channel slots in the packed color arrays.
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef struct packed {
    logic [2:0] pixel_bytes;
    logic [3:0] red_length;
    logic [4:0] red_offset;
    logic [3:0] green_length;
    logic [4:0] green_offset;
    logic [3:0] blue_length;
    logic [4:0] blue_offset;
    logic       fill_background;
  } cfg_t;

  typedef struct packed {
    logic [7:0] coverage;
    logic [3:0] fg_index;
    logic [3:0] bg_index;
    logic       last_in_row;
  } glyph_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        write_enable;
    logic        row_end;
  } pixel_t;

  // After palette lookup: background color and the magnitude and sign of fg - bg.
  typedef struct packed {
    logic [7:0]      coverage;
    logic [3:0]      fg_idx;
    logic [3:0]      bg_idx;
    logic [2:0][7:0] bg_rgb;
    logic [2:0][7:0] diff_mag;
    logic [2:0]      diff_neg;
    logic            last;
  } lookup_t;

  // After the multiply: |fg - bg| * coverage per channel.
  typedef struct packed {
    logic [7:0]       coverage;
    logic [3:0]       fg_idx;
    logic [3:0]       bg_idx;
    logic [2:0][7:0]  bg_rgb;
    logic [2:0][15:0] prod;
    logic [2:0]       diff_neg;
    logic             last;
  } product_t;

  // After the divide and add: blended 8-bit channels.
  typedef struct packed {
    logic [7:0]      coverage;
    logic [3:0]      fg_idx;
    logic [3:0]      bg_idx;
    logic [2:0][7:0] rgb;
    logic            last;
  } blended_t;

  // Reduces an index modulo the palette size by repeated compare and subtract.
  function automatic logic [3:0] fold_index(input logic [3:0] raw);
    logic [8:0] v;
    v = {5'b0, raw};
    for (int i = 0; i < 8; i++) begin
      if (v >= PALETTE_SIZE_V) begin
        v = v - PALETTE_SIZE_V;
      end
    end
    return v[3:0];
  endfunction

  // 16-color palette, red in slot 0, blue in slot 2.
  function automatic logic [2:0][7:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] c;
    unique case (idx)
      4'd0:  c = 24'h000000;
      4'd1:  c = 24'h0000aa;
      4'd2:  c = 24'h00aa00;
      4'd3:  c = 24'h0055aa;
      4'd4:  c = 24'haa0000;
      4'd5:  c = 24'haa00aa;
      4'd6:  c = 24'haaaa00;
      4'd7:  c = 24'haaaaaa;
      4'd8:  c = 24'h555555;
      4'd9:  c = 24'h5555ff;
      4'd10: c = 24'h55ff55;
      4'd11: c = 24'h55ffff;
      4'd12: c = 24'hff5555;
      4'd13: c = 24'hff55ff;
      4'd14: c = 24'hffff55;
      4'd15: c = 24'hffffff;
    endcase
    return {c[7:0], c[15:8], c[23:16]};
  endfunction

endpackage

>>> rtl/core/gpbp_lookup.sv
module gpbp_lookup (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  gpbp_pkg::glyph_t     up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output gpbp_pkg::lookup_t    dn_data
);

  logic              valid;
  gpbp_pkg::lookup_t data;
  gpbp_pkg::lookup_t data_next;
  logic [2:0][7:0]   fg_rgb;
  logic [2:0][7:0]   bg_rgb;

  always_comb begin
    data_next.coverage = up_data.coverage;
    data_next.fg_idx   = gpbp_pkg::fold_index(up_data.fg_index);
    data_next.bg_idx   = gpbp_pkg::fold_index(up_data.bg_index);
    data_next.last     = up_data.last_in_row;
    fg_rgb = gpbp_pkg::palette_rgb(data_next.fg_idx);
    bg_rgb = gpbp_pkg::palette_rgb(data_next.bg_idx);
    data_next.bg_rgb = bg_rgb;
    for (int c = 0; c < 3; c++) begin
      data_next.diff_neg[c] = fg_rgb[c] < bg_rgb[c];
      data_next.diff_mag[c] = data_next.diff_neg[c] ? (bg_rgb[c] - fg_rgb[c])
                                                    : (fg_rgb[c] - bg_rgb[c]);
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

>>> rtl/core/gpbp_blend.sv
module gpbp_blend (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  gpbp_pkg::lookup_t    up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output gpbp_pkg::blended_t   dn_data
);

  // Multiply stage.
  logic               mul_valid;
  logic               mul_ready;
  gpbp_pkg::product_t mul_data;
  gpbp_pkg::product_t mul_next;

  // Divide and add stage.
  logic               div_valid;
  logic               div_ready;
  gpbp_pkg::blended_t div_data;
  gpbp_pkg::blended_t div_next;
  logic [2:0][16:0]   div_sum;
  logic [2:0][7:0]    quot;

  always_comb begin
    mul_next.coverage = up_data.coverage;
    mul_next.fg_idx   = up_data.fg_idx;
    mul_next.bg_idx   = up_data.bg_idx;
    mul_next.bg_rgb   = up_data.bg_rgb;
    mul_next.diff_neg = up_data.diff_neg;
    mul_next.last     = up_data.last;
    for (int c = 0; c < 3; c++) begin
      mul_next.prod[c] = 16'(up_data.diff_mag[c]) * 16'(up_data.coverage);
    end
  end

  // The product never exceeds 255 * 255, so a / 255 equals (a + (a >> 8) + 1) >> 8.
  // Working on the magnitude makes the quotient truncate toward zero.
  always_comb begin
    div_next.coverage = mul_data.coverage;
    div_next.fg_idx   = mul_data.fg_idx;
    div_next.bg_idx   = mul_data.bg_idx;
    div_next.last     = mul_data.last;
    for (int c = 0; c < 3; c++) begin
      div_sum[c] = {1'b0, mul_data.prod[c]} + 17'(mul_data.prod[c][15:8]) + 17'd1;
      quot[c]    = div_sum[c][15:8];
      div_next.rgb[c] = mul_data.diff_neg[c] ? (mul_data.bg_rgb[c] - quot[c])
                                             : (mul_data.bg_rgb[c] + quot[c]);
    end
  end

  assign div_ready = !div_valid || dn_ready;
  assign mul_ready = !mul_valid || div_ready;
  assign up_ready  = mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      div_valid <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid <= up_valid;
      end
      if (div_ready) begin
        div_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && up_valid) begin
      mul_data <= mul_next;
    end
    if (div_ready && mul_valid) begin
      div_data <= div_next;
    end
  end

  assign dn_valid = div_valid;
  assign dn_data  = div_data;

endmodule

>>> rtl/core/gpbp_pack.sv
module gpbp_pack (
  input  logic                 clk,
  input  logic                 rst,
  input  gpbp_pkg::cfg_t       cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  gpbp_pkg::blended_t   up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output gpbp_pkg::pixel_t     dn_data
);

  logic             valid;
  gpbp_pkg::pixel_t data;
  gpbp_pkg::pixel_t data_next;
  logic             is_fg;
  logic [31:0]      packed_word;

  // Keeps the top bits of a channel and moves them to their field position.
  function automatic logic [31:0] place(input logic [7:0] v, input logic [3:0] len,
                                        input logic [4:0] off);
    logic [3:0] l;
    logic [7:0] s;
    l = (len > 4'd8) ? 4'd8 : len;
    s = v >> (4'd8 - l);
    if (l == 4'd0) begin
      s = 8'd0;
    end
    return {24'b0, s} << off;
  endfunction

  always_comb begin
    packed_word = place(up_data.rgb[gpbp_pkg::CH_RED], cfg.red_length, cfg.red_offset)
                | place(up_data.rgb[gpbp_pkg::CH_GREEN], cfg.green_length, cfg.green_offset)
                | place(up_data.rgb[gpbp_pkg::CH_BLUE], cfg.blue_length, cfg.blue_offset);
    is_fg = 1'b0;
    data_next.row_end = up_data.last;
    unique case (cfg.pixel_bytes)
      gpbp_pkg::PB_INDEXED: begin
        is_fg = up_data.coverage[7];
        data_next.pixel_word   = {28'b0, is_fg ? up_data.fg_idx : up_data.bg_idx};
        data_next.write_enable = cfg.fill_background || is_fg;
      end
      gpbp_pkg::PB_RGB16: begin
        is_fg = up_data.coverage != 8'd0;
        data_next.pixel_word   = {16'b0, packed_word[15:0]};
        data_next.write_enable = cfg.fill_background || is_fg;
      end
      gpbp_pkg::PB_RGB32: begin
        is_fg = up_data.coverage != 8'd0;
        data_next.pixel_word   = packed_word;
        data_next.write_enable = cfg.fill_background || is_fg;
      end
      default: begin
        data_next.pixel_word   = 32'd0;
        data_next.write_enable = 1'b0;
      end
    endcase
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

>>> rtl/core/glyph_pixel_blend_pack.sv
// Glyph pixel blend and pack. Each glyph transaction carries a coverage byte, a
// foreground and a background index into the 16-color palette, and a row-end
// mark; each pixel transaction returns one framebuffer word, its write enable and
// the row-end mark. The block takes one transaction per clock while the pixel side
// does not stall and passes it through four register stages: palette lookup,
// channel multiply, divide by 255 with the add of the background, and field
// packing. Stall on the pixel side holds the pipeline in place; empty stages still
// fill, so the glyph side keeps moving until every stage holds a transaction. In
// indexed mode (pixel_bytes 1) bit 7 of coverage picks the foreground or
// background index as the pixel; in packed modes (2 or 4) each channel is
// blended as bg + (fg - bg) * coverage / 255, truncated toward zero, then cut
// to its length and placed at its offset. Any other pixel_bytes value gives a
// zero word that is never written. Configuration writes take effect at once and
// must only be issued while no glyph transaction is in flight.
module glyph_pixel_blend_pack (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gpbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gpbp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                glyph_valid,
  output logic                                glyph_stall,
  input  gpbp_pkg::glyph_t                    glyph,
  output logic                                pix_valid,
  input  logic                                pix_stall,
  output gpbp_pkg::pixel_t                    pix
);

  gpbp_pkg::cfg_t     cfg;
  logic               glyph_ready;
  logic               lk_valid;
  logic               lk_ready;
  gpbp_pkg::lookup_t  lk_data;
  logic               bl_valid;
  logic               bl_ready;
  gpbp_pkg::blended_t bl_data;

  // Configuration registers. Reset leaves the block in 32-bit RGB888 with
  // background fill on.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_bytes     <= gpbp_pkg::PB_RGB32;
      cfg.red_length      <= 4'd8;
      cfg.red_offset      <= 5'd16;
      cfg.green_length    <= 4'd8;
      cfg.green_offset    <= 5'd8;
      cfg.blue_length     <= 4'd8;
      cfg.blue_offset     <= 5'd0;
      cfg.fill_background <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gpbp_pkg::REG_PIXEL_BYTES:     cfg.pixel_bytes     <= cfg_data[2:0];
        gpbp_pkg::REG_RED_LENGTH:      cfg.red_length      <= cfg_data[3:0];
        gpbp_pkg::REG_RED_OFFSET:      cfg.red_offset      <= cfg_data;
        gpbp_pkg::REG_GREEN_LENGTH:    cfg.green_length    <= cfg_data[3:0];
        gpbp_pkg::REG_GREEN_OFFSET:    cfg.green_offset    <= cfg_data;
        gpbp_pkg::REG_BLUE_LENGTH:     cfg.blue_length     <= cfg_data[3:0];
        gpbp_pkg::REG_BLUE_OFFSET:     cfg.blue_offset     <= cfg_data;
        gpbp_pkg::REG_FILL_BACKGROUND: cfg.fill_background <= cfg_data[0];
      endcase
    end
  end

  // The glyph side stalls only when the first stage is full and cannot drain.
  assign glyph_stall = !glyph_ready;

  // Stage one: fold the indexes, look up both colors, form |fg - bg| and its sign.
  gpbp_lookup u_lookup (
    .clk      (clk),
    .rst      (rst),
    .up_valid (glyph_valid),
    .up_ready (glyph_ready),
    .up_data  (glyph),
    .dn_valid (lk_valid),
    .dn_ready (lk_ready),
    .dn_data  (lk_data)
  );

  // Stages two and three: multiply by coverage, then divide by 255 and add.
  gpbp_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .up_valid (lk_valid),
    .up_ready (lk_ready),
    .up_data  (lk_data),
    .dn_valid (bl_valid),
    .dn_ready (bl_ready),
    .dn_data  (bl_data)
  );

  // Stage four: pack the channels or pick the index, and register the pixel.
  gpbp_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (bl_valid),
    .up_ready (bl_ready),
    .up_data  (bl_data),
    .dn_valid (pix_valid),
    .dn_ready (!pix_stall),
    .dn_data  (pix)
  );

`ifndef SYNTHESIS
  // Unsupported pixel sizes must never write.
  a_bad_size_no_write: assert property (@(posedge clk) disable iff (rst)
    pix_valid && cfg.pixel_bytes != gpbp_pkg::PB_INDEXED
      && cfg.pixel_bytes != gpbp_pkg::PB_RGB16 && cfg.pixel_bytes != gpbp_pkg::PB_RGB32
      |-> !pix.write_enable && pix.pixel_word == 32'd0)
    else $error("write enabled for unsupported pixel size");

  // Indexed pixels fit in four bits.
  a_indexed_width: assert property (@(posedge clk) disable iff (rst)
    pix_valid && cfg.pixel_bytes == gpbp_pkg::PB_INDEXED |-> pix.pixel_word[31:4] == 28'd0)
    else $error("indexed pixel wider than the palette index");

  // 16-bit pixels are masked to the low half-word.
  a_rgb16_mask: assert property (@(posedge clk) disable iff (rst)
    pix_valid && cfg.pixel_bytes == gpbp_pkg::PB_RGB16 |-> pix.pixel_word[31:16] == 16'd0)
    else $error("16-bit pixel not masked");

  // With background fill on, every supported pixel is written.
  a_fill_writes: assert property (@(posedge clk) disable iff (rst)
    pix_valid && cfg.fill_background
      && (cfg.pixel_bytes == gpbp_pkg::PB_INDEXED || cfg.pixel_bytes == gpbp_pkg::PB_RGB16
          || cfg.pixel_bytes == gpbp_pkg::PB_RGB32)
      |-> pix.write_enable)
    else $error("background fill on but pixel not written");

  // An accepted glyph reaches the output through the pipeline registers when the pixel side does not stall.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (glyph_valid && !glyph_stall) ##1 !pix_stall ##1 !pix_stall ##1 !pix_stall
      |=> pix_valid)
    else $error("pixel transaction missing after pipeline latency");
`endif

endmodule
